### design/qhs_pkg.sv
// Package for the quadratic-chain hash set: request/result payload types,
// the end-of-chain displacement marker, the default load limit, opcodes and status codes. No dependencies.
package qhs_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [63:0] hash_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  bucket_index;
    logic [10:0] key_count;
  } rsp_t;

  // seq <-> top control group
  typedef struct packed {
    logic idle;
    logic done;
  } seq_ctl_t;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_NEW    = 2'd0;
  localparam logic [1:0] ST_FOUND  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [10:0] DISP_END      = 11'h7FF;
  localparam logic [10:0] MAX_LOAD_INIT = 11'd921;

endpackage

### design/qhs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/qhs_seq.sv
// Sequencer of the hash set: holds the metadata, key and home-index memories
// and walks probe chains through one shared link-address unit.
// Depends on qhs_pkg and qhs_ram.
module qhs_seq #(
  parameter int NUM_BUCKETS = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  qhs_pkg::req_t    req,
  input  logic             take,
  input  logic [10:0]      max_load,
  output qhs_pkg::seq_ctl_t ctl,
  output qhs_pkg::rsp_t    res
);

  localparam int IDXW = $clog2(NUM_BUCKETS);
  localparam int CNTW = IDXW + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WAIT = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_HEAD = 4'd3;
  localparam logic [3:0] S_LK   = 4'd4;
  localparam logic [3:0] S_RM   = 4'd5;
  localparam logic [3:0] S_RM2  = 4'd6;
  localparam logic [3:0] S_RM3  = 4'd7;
  localparam logic [3:0] S_FF   = 4'd8;
  localparam logic [3:0] S_PR   = 4'd9;
  localparam logic [3:0] S_EZ   = 4'd10;
  localparam logic [3:0] S_CS   = 4'd11;
  localparam logic [3:0] S_CS2  = 4'd12;
  localparam logic [3:0] S_INS  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;

  logic [3:0]           state, ret;
  logic [IDXW-1:0]      raddr, idx, home, h, cur, prev, at, tgt, e, lin, bucket;
  logic [1:0]           op, status;
  logic [KEY_WIDTH-1:0] keyr, kb;
  logic [3:0]           frag;
  logic [15:0]          mb, mprev;
  logic [10:0]          de, cs_disp;
  logic                 evict, sweep_rsp;
  logic [CNTW-1:0]      count;

  logic                 meta_we, key_we, home_we;
  logic [IDXW-1:0]      meta_wa, key_wa, home_wa;
  logic [15:0]          meta_wd, rd_meta;
  logic [KEY_WIDTH-1:0] key_wd, rd_key;
  logic [IDXW-1:0]      home_wd, rd_home;

  // Shared link unit: base + d*(d+1)/2, modulo bucket count.
  function automatic logic [IDXW-1:0] link_to(input logic [IDXW-1:0] base,
                                              input logic [10:0] d);
    logic [22:0] prod;
    prod = 23'(d) * 23'({1'b0, d} + 12'd1);
    return base + IDXW'(prod >> 1);
  endfunction

  logic [10:0]     rd_disp;
  logic [IDXW-1:0] link_nx, ff_next;
  logic            is_match, room, rd_home_flag;

  assign rd_disp      = rd_meta[10:0];
  assign rd_home_flag = rd_meta[11];
  assign link_nx      = link_to(h, rd_disp);
  assign is_match     = (rd_meta[15:12] == frag) && (rd_key == keyr);
  assign room         = (32'(count) + 32'd1) <= 32'(max_load);
  assign ff_next      = h + lin + IDXW'(de) + IDXW'(1);

  qhs_ram #(.WIDTH(16), .DEPTH(NUM_BUCKETS)) u_meta (
    .clk, .we(meta_we), .waddr(meta_wa), .wdata(meta_wd), .raddr, .rdata(rd_meta));
  qhs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(NUM_BUCKETS)) u_key (
    .clk, .we(key_we), .waddr(key_wa), .wdata(key_wd), .raddr, .rdata(rd_key));
  qhs_ram #(.WIDTH(IDXW), .DEPTH(NUM_BUCKETS)) u_home (
    .clk, .we(home_we), .waddr(home_wa), .wdata(home_wd), .raddr, .rdata(rd_home));

  always_comb begin
    meta_we = 1'b0; meta_wa = cur; meta_wd = 16'd0;
    key_we  = 1'b0; key_wa  = cur; key_wd  = keyr;
    home_we = 1'b0; home_wa = cur; home_wd = home;
    case (state)
      S_CLR: begin
        meta_we = 1'b1; meta_wa = idx;
      end
      S_LK: begin
        if (is_match && op == qhs_pkg::OP_INSERT) begin
          key_we = 1'b1;
        end
        if (is_match && op == qhs_pkg::OP_ERASE && rd_disp == qhs_pkg::DISP_END &&
            rd_home_flag) begin
          meta_we = 1'b1;
        end
      end
      S_RM: begin
        if (rd_disp == qhs_pkg::DISP_END) begin
          meta_we = 1'b1; meta_wa = at; meta_wd = {rd_meta[15:12], mb[11:0]};
          key_we  = 1'b1; key_wa  = at; key_wd  = rd_key;
          home_we = 1'b1; home_wa = at; home_wd = rd_home;
        end
      end
      S_RM2: begin
        meta_we = 1'b1; meta_wa = prev;
        meta_wd = (prev == at) ? (mb | 16'h07FF) : (mprev | 16'h07FF);
      end
      S_RM3: meta_we = 1'b1;
      S_FF: begin
        if (rd_meta == 16'd0 && !evict) begin
          key_we = 1'b1; key_wa = raddr;
          home_we = 1'b1; home_wa = raddr;
        end
      end
      S_PR: begin
        if (link_nx == tgt) begin
          meta_we = 1'b1;
          if (evict) begin
            meta_wd = {rd_meta[15:11], mb[10:0]};
            key_we  = 1'b1; key_wa = e; key_wd = kb;
            home_we = 1'b1; home_wa = e; home_wd = h;
          end else begin
            meta_wd = rd_meta | 16'h07FF;
          end
        end
      end
      S_EZ: begin
        meta_we = 1'b1; meta_wa = at;
      end
      S_CS: begin
        if (rd_disp > de) begin
          meta_we = 1'b1; meta_wd = {rd_meta[15:11], de};
        end
      end
      S_CS2: begin
        meta_we = 1'b1; meta_wa = e;
        meta_wd = {(evict ? mb[15:12] : frag), 1'b0, cs_disp};
      end
      S_INS: begin
        meta_we = 1'b1; meta_wa = home; meta_wd = {frag, 1'b1, qhs_pkg::DISP_END};
        key_we  = 1'b1; key_wa  = home;
        home_we = 1'b1; home_wa = home;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      idx       <= '0;
      sweep_rsp <= 1'b0;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= req.opcode;
            keyr   <= KEY_WIDTH'(64'(req.key));
            home   <= req.hash_value[IDXW-1:0];
            h      <= req.hash_value[IDXW-1:0];
            cur    <= req.hash_value[IDXW-1:0];
            frag   <= req.hash_value[63:60];
            evict  <= 1'b0;
            status <= qhs_pkg::ST_ABSENT;
            bucket <= '0;
            if (req.opcode == qhs_pkg::OP_CLEAR) begin
              idx       <= '0;
              sweep_rsp <= 1'b1;
              count     <= '0;
              status    <= qhs_pkg::ST_FOUND;
              state     <= S_CLR;
            end else begin
              raddr <= req.hash_value[IDXW-1:0];
              ret   <= S_HEAD;
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: state <= ret;
        S_CLR: begin
          idx <= idx + IDXW'(1);
          if (idx == IDXW'(NUM_BUCKETS - 1)) begin
            state <= sweep_rsp ? S_FIN : S_IDLE;
          end
        end
        S_HEAD: begin
          if (op != qhs_pkg::OP_INSERT || rd_home_flag) begin
            state <= rd_home_flag ? S_LK : S_FIN;
          end else if (!room) begin
            status <= qhs_pkg::ST_FULL;
            state  <= S_FIN;
          end else if (rd_meta == 16'd0) begin
            state <= S_INS;
          end else begin
            evict <= 1'b1;
            mb    <= rd_meta;
            kb    <= rd_key;
            h     <= rd_home;
            de    <= 11'd1;
            lin   <= IDXW'(1);
            raddr <= rd_home + IDXW'(1);
            ret   <= S_FF;
            state <= S_WAIT;
          end
        end
        S_LK: begin
          if (is_match) begin
            at     <= cur;
            status <= qhs_pkg::ST_FOUND;
            bucket <= cur;
            state  <= S_FIN;
            if (op == qhs_pkg::OP_ERASE) begin
              if (count != '0) begin
                count <= count - CNTW'(1);
              end
              mb <= rd_meta;
              if (rd_disp == qhs_pkg::DISP_END) begin
                if (!rd_home_flag) begin
                  // tail of chain: unlink from predecessor
                  tgt   <= cur;
                  cur   <= home;
                  raddr <= home;
                  ret   <= S_PR;
                  state <= S_WAIT;
                end
              end else begin
                prev  <= cur;
                mprev <= rd_meta;
                cur   <= link_nx;
                raddr <= link_nx;
                ret   <= S_RM;
                state <= S_WAIT;
              end
            end
          end else if (rd_disp == qhs_pkg::DISP_END) begin
            if (op != qhs_pkg::OP_INSERT) begin
              state <= S_FIN;
            end else if (!room) begin
              status <= qhs_pkg::ST_FULL;
              state  <= S_FIN;
            end else begin
              de    <= 11'd1;
              lin   <= IDXW'(1);
              raddr <= home + IDXW'(1);
              ret   <= S_FF;
              state <= S_WAIT;
            end
          end else begin
            cur   <= link_nx;
            raddr <= link_nx;
            ret   <= S_LK;
            state <= S_WAIT;
          end
        end
        S_RM: begin
          if (rd_disp == qhs_pkg::DISP_END) begin
            mb    <= {rd_meta[15:12], mb[11:0]};
            state <= S_RM2;
          end else begin
            prev  <= cur;
            mprev <= rd_meta;
            cur   <= link_nx;
            raddr <= link_nx;
            ret   <= S_RM;
            state <= S_WAIT;
          end
        end
        S_RM2: state <= S_RM3;
        S_RM3: state <= S_FIN;
        S_FF: begin
          if (rd_meta == 16'd0) begin
            e     <= raddr;
            cur   <= h;
            tgt   <= home;
            raddr <= h;
            ret   <= evict ? S_PR : S_CS;
            state <= S_WAIT;
          end else if (de + 11'd1 == qhs_pkg::DISP_END) begin
            status <= qhs_pkg::ST_FULL;
            state  <= S_FIN;
          end else begin
            de    <= de + 11'd1;
            lin   <= lin + IDXW'(de) + IDXW'(1);
            raddr <= ff_next;
            ret   <= S_FF;
            state <= S_WAIT;
          end
        end
        S_PR: begin
          if (link_nx == tgt) begin
            if (evict) begin
              cur   <= h;
              raddr <= h;
              ret   <= S_CS;
              state <= S_WAIT;
            end else begin
              state <= S_EZ;
            end
          end else begin
            cur   <= link_nx;
            raddr <= link_nx;
            ret   <= S_PR;
            state <= S_WAIT;
          end
        end
        S_EZ: state <= S_FIN;
        S_CS: begin
          if (rd_disp > de) begin
            cs_disp <= rd_disp;
            state   <= S_CS2;
          end else begin
            cur   <= link_nx;
            raddr <= link_nx;
            ret   <= S_CS;
            state <= S_WAIT;
          end
        end
        S_CS2: begin
          if (evict) begin
            state <= S_INS;
          end else begin
            count  <= count + CNTW'(1);
            status <= qhs_pkg::ST_NEW;
            bucket <= e;
            state  <= S_FIN;
          end
        end
        S_INS: begin
          count  <= count + CNTW'(1);
          status <= qhs_pkg::ST_NEW;
          bucket <= home;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ctl.idle = (state == S_IDLE);
  assign ctl.done = (state == S_FIN);
  assign res.status       = status;
  assign res.bucket_index = 10'(bucket);
  assign res.key_count    = 11'(count);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= NUM_BUCKETS)
    else $error("key count beyond bucket count");

  a_miss_bucket_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && (status == qhs_pkg::ST_ABSENT || status == qhs_pkg::ST_FULL))
      |-> bucket == '0)
    else $error("bucket index set on miss or full");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !take) |=> state == S_FIN)
    else $error("result dropped before hand-off");

  a_new_counts: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && status == qhs_pkg::ST_NEW) |-> count != '0)
    else $error("new key reported with empty table");
`endif

endmodule

### design/quadratic_chain_hash_set_top.sv
// Top level of the quadratic-chain hash set: request/result handshakes,
// max_load register and result register. Depends on qhs_pkg, qhs_seq.
//
// One request is worked on at a time; req_ready is high only while the
// sequencer is idle. Every metadata/key read goes through the single read
// address shared by the three memories and waits in S_WAIT for the registered
// data, so a lookup pays one read per chain link; an insert adds a free-slot
// probe (one read per probed bucket) and a chain walk to splice the new key
// in, and an eviction adds a predecessor walk on top. Clear writes one bucket
// per cycle. After reset the same clearing pass runs with req_ready low. A
// finished result waits in the output register while the next request is accepted.
module quadratic_chain_hash_set_top #(
  parameter int NUM_BUCKETS = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  qhs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output qhs_pkg::rsp_t rsp,
  input  logic          cfg_write_en,
  input  logic [10:0]   cfg_write_data
);

  logic [10:0]       max_load;
  qhs_pkg::seq_ctl_t ctl;
  qhs_pkg::rsp_t     res;
  logic              take;

  assign req_ready = ctl.idle;
  assign take      = ctl.done && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_load <= qhs_pkg::MAX_LOAD_INIT;
    end else if (cfg_write_en) begin
      max_load <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= res;
    end
  end

  qhs_seq #(.NUM_BUCKETS(NUM_BUCKETS), .KEY_WIDTH(KEY_WIDTH)) u_seq (
    .clk,
    .rst,
    .start(req_valid && req_ready),
    .req,
    .take,
    .max_load,
    .ctl,
    .res
  );

endmodule

### tb/tb_top.sv
// Self-checking testbench for quadratic_chain_hash_set_top: a behavioural copy of the
// hash set predicts every result, and a checker process compares each one field by field.
// Depends on qhs_pkg and the design sources.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 1024;
  localparam logic [10:0] END_LINK = 11'h7FF;
  localparam int LIMIT_CYCLES = 60000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  qhs_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  qhs_pkg::rsp_t rsp;
  logic cfg_write_en = 1'b0;
  logic [10:0] cfg_write_data = '0;

  quadratic_chain_hash_set_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  // predictor state
  logic [15:0] meta [NB];
  logic [31:0] keys [NB];
  logic [9:0]  homes [NB];
  int unsigned held;
  int unsigned load_limit;

  qhs_pkg::rsp_t pending [$];
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;   // percent
  int recv_gap = 0;
  logic [31:0] used_keys [$];

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("quadratic_chain_hash_set_top: mismatch");
      $finish;
    end
  end

  function automatic logic [9:0] link_at(logic [9:0] h, int unsigned d);
    return 10'((h + (d * d + d) / 2) % NB);
  endfunction

  function automatic bit free_slot(logic [9:0] h, output logic [9:0] s, output int unsigned d);
    int unsigned lin;
    d = 1;
    lin = 1;
    forever begin
      s = 10'((h + lin) % NB);
      if (meta[s] == 16'h0) return 1'b1;
      d++;
      if (d == END_LINK) return 1'b0;
      lin += d;
    end
  endfunction

  function automatic logic [9:0] splice_point(logic [9:0] h, int unsigned tgt);
    logic [9:0] c;
    c = h;
    for (int n = 0; n < 2048; n++) begin
      if (meta[c][10:0] > tgt) return c;
      c = link_at(h, meta[c][10:0]);
    end
    return c;
  endfunction

  function automatic logic [9:0] pred_of(logic [9:0] h, logic [9:0] b);
    logic [9:0] p, nx;
    p = h;
    for (int n = 0; n < 2048; n++) begin
      nx = link_at(h, meta[p][10:0]);
      if (nx == b) return p;
      p = nx;
    end
    return h;
  endfunction

  function automatic void splice(logic [9:0] h, logic [9:0] s, int unsigned d, logic [15:0] frag);
    logic [9:0] p;
    p = splice_point(h, d);
    meta[s] = frag | {5'b0, meta[p][10:0]};
    meta[p][10:0] = 11'(d);
  endfunction

  function automatic bit displace(logic [9:0] b);
    logic [9:0] h, e, p;
    int unsigned d;
    h = homes[b];
    if (!free_slot(h, e, d)) return 1'b0;
    p = pred_of(h, b);
    meta[p][10:0] = meta[b][10:0];
    keys[e] = keys[b];
    homes[e] = h;
    splice(h, e, d, meta[b] & 16'hF000);
    return 1'b1;
  endfunction

  function automatic bit search(logic [9:0] h, logic [15:0] frag, logic [31:0] k,
                                output logic [9:0] at);
    logic [9:0] b;
    b = h;
    at = '0;
    if (!meta[h][11]) return 1'b0;
    for (int n = 0; n < 2048; n++) begin
      if ((meta[b] & 16'hF000) == frag && keys[b] == k) begin
        at = b;
        return 1'b1;
      end
      if (meta[b][10:0] == END_LINK) return 1'b0;
      b = link_at(h, meta[b][10:0]);
    end
    return 1'b0;
  endfunction

  function automatic void unlink(logic [9:0] h, logic [9:0] b);
    logic [15:0] m;
    logic [9:0] cur, prv, p;
    m = meta[b];
    cur = b;
    if (held > 0) held--;
    if (m[10:0] == END_LINK) begin
      if (!m[11]) begin
        p = pred_of(h, b);
        meta[p][10:0] = END_LINK;
      end
      meta[b] = '0;
      return;
    end
    for (int n = 0; n < 2048; n++) begin
      prv = cur;
      cur = link_at(h, meta[cur][10:0]);
      if (meta[cur][10:0] == END_LINK) begin
        keys[b] = keys[cur];
        homes[b] = homes[cur];
        meta[b][15:12] = meta[cur][15:12];
        meta[prv][10:0] = END_LINK;
        meta[cur] = '0;
        return;
      end
    end
  endfunction

  function automatic qhs_pkg::rsp_t apply_request(qhs_pkg::req_t r);
    qhs_pkg::rsp_t o;
    logic [9:0] h, at, e;
    logic [15:0] frag;
    int unsigned d;
    h = r.hash_value[9:0];
    frag = {r.hash_value[63:60], 12'h0};
    o.status = qhs_pkg::ST_ABSENT;
    o.bucket_index = '0;
    case (r.opcode)
      qhs_pkg::OP_CLEAR: begin
        foreach (meta[i]) meta[i] = '0;
        held = 0;
        o.status = qhs_pkg::ST_FOUND;
      end
      qhs_pkg::OP_LOOKUP: begin
        if (search(h, frag, r.key, at)) begin
          o.status = qhs_pkg::ST_FOUND;
          o.bucket_index = at;
        end
      end
      qhs_pkg::OP_ERASE: begin
        if (search(h, frag, r.key, at)) begin
          unlink(h, at);
          o.status = qhs_pkg::ST_FOUND;
          o.bucket_index = at;
        end
      end
      default: begin
        if (!meta[h][11]) begin
          o.status = qhs_pkg::ST_FULL;
          if (held + 1 <= load_limit && (meta[h] == 16'h0 || displace(h))) begin
            keys[h] = r.key;
            homes[h] = h;
            meta[h] = frag | 16'h0FFF;
            held++;
            o.status = qhs_pkg::ST_NEW;
            o.bucket_index = h;
          end
        end else if (search(h, frag, r.key, at)) begin
          keys[at] = r.key;
          o.status = qhs_pkg::ST_FOUND;
          o.bucket_index = at;
        end else begin
          o.status = qhs_pkg::ST_FULL;
          if (held + 1 <= load_limit && free_slot(h, e, d)) begin
            keys[e] = r.key;
            homes[e] = h;
            splice(h, e, d, frag);
            held++;
            o.status = qhs_pkg::ST_NEW;
            o.bucket_index = e;
          end
        end
      end
    endcase
    o.key_count = 11'(held);
    return o;
  endfunction

  // result checker with random back-pressure
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", rsp);
        end else begin
          qhs_pkg::rsp_t want;
          want = pending.pop_front();
          if (rsp.status !== want.status || rsp.bucket_index !== want.bucket_index ||
              rsp.key_count !== want.key_count) begin
            errors++;
            if (errors <= 10) $display("result: expected %p got %p", want, rsp);
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_gap);
    end
  end

  task automatic send_request(logic [1:0] op, logic [31:0] k, logic [63:0] hv);
    qhs_pkg::req_t r;
    while ($urandom_range(99) < send_gap) @(posedge clk);
    r.opcode = op;
    r.key = k;
    r.hash_value = hv;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pending.push_back(apply_request(r));
    req_valid <= 1'b0;
    // the block is busy on the next edge; stepping past it keeps one drive per edge
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_load_limit(logic [10:0] v);
    drain();
    cfg_write_data <= v;
    cfg_write_en <= 1'b1;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    load_limit = v;
  endtask

  // hash whose low bits pick one of few homes so chains grow long
  function automatic logic [63:0] crowded_hash(int spread);
    logic [63:0] hv;
    hv = {$urandom, $urandom};
    hv[9:0] = 10'($urandom_range(spread - 1) * 3);
    return hv;
  endfunction

  task automatic test_directed();
    send_request(qhs_pkg::OP_LOOKUP, 32'h0, 64'h0);
    send_request(qhs_pkg::OP_INSERT, 32'h0, 64'h0);
    send_request(qhs_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(qhs_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);   // replace
    send_request(qhs_pkg::OP_INSERT, 32'h1, 64'h0);                      // same home
    send_request(qhs_pkg::OP_INSERT, 32'h2, 64'h1);                      // displaced key evicted
    send_request(qhs_pkg::OP_INSERT, 32'h3, 64'h3);
    send_request(qhs_pkg::OP_LOOKUP, 32'h1, 64'h0);
    send_request(qhs_pkg::OP_LOOKUP, 32'h1, 64'h5000_0000_0000_0000);   // wrong fragment
    send_request(qhs_pkg::OP_ERASE, 32'h0, 64'h0);                       // chain tail moves up
    send_request(qhs_pkg::OP_ERASE, 32'h0, 64'h0);
    send_request(qhs_pkg::OP_ERASE, 32'h1, 64'h0);
    send_request(qhs_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(qhs_pkg::OP_CLEAR, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(qhs_pkg::OP_LOOKUP, 32'h2, 64'h1);
    set_load_limit(11'd0);
    send_request(qhs_pkg::OP_INSERT, 32'h5, 64'h5);                      // full at limit zero
    set_load_limit(11'd2);
    send_request(qhs_pkg::OP_INSERT, 32'h5, 64'h5);
    send_request(qhs_pkg::OP_INSERT, 32'h6, 64'h5);
    send_request(qhs_pkg::OP_INSERT, 32'h7, 64'h6);                      // full at limit
    send_request(qhs_pkg::OP_INSERT, 32'h6, 64'h5);                      // replace at limit
    send_request(qhs_pkg::OP_CLEAR, 32'h0, 64'h0);
  endtask

  task automatic test_random(int n, int spread);
    logic [31:0] k;
    logic [63:0] hv;
    logic [1:0] op;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 55 || used_keys.size() == 0) begin
        op = qhs_pkg::OP_INSERT;
        k = $urandom;
        used_keys.push_back(k);
      end else begin
        op = (pick < 78) ? qhs_pkg::OP_LOOKUP :
             (pick < 99) ? qhs_pkg::OP_ERASE : qhs_pkg::OP_CLEAR;
        k = ($urandom_range(3) == 0) ? $urandom : used_keys[$urandom_range(used_keys.size() - 1)];
      end
      // hash derived from key so repeat keys hit the same chain
      hv = {k[3:0] ^ k[31:28], k[27:0] ^ 28'h5A5A5A5, k ^ 32'h9E3779B9};
      hv[9:0] = 10'((k % spread) * 7);
      if (op == qhs_pkg::OP_CLEAR) used_keys.delete();
      if (used_keys.size() > 400) void'(used_keys.pop_front());
      send_request(op, k, hv);
    end
  endtask

  task automatic test_fill();
    set_load_limit(11'd1024);
    for (int i = 0; i < 260; i++) send_request(qhs_pkg::OP_INSERT, $urandom, crowded_hash(40));
    drain();   // sender holds off until every result is in
    for (int i = 0; i < 60; i++) send_request(qhs_pkg::OP_ERASE, $urandom, crowded_hash(40));
    send_request(qhs_pkg::OP_CLEAR, '0, '0);
  endtask

  initial begin
    foreach (meta[i]) begin
      meta[i] = '0;
      keys[i] = '0;
      homes[i] = '0;
    end
    held = 0;
    load_limit = 921;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_gap = 7;
    recv_gap = 86;
    test_directed();
    set_load_limit(11'd921);
    test_random(300, 200);
    send_gap = 86;
    recv_gap = 7;
    set_load_limit(11'd60);
    test_random(300, 30);
    send_gap = 0;
    recv_gap = 0;
    test_fill();
    set_load_limit(11'd1023);
    test_random(600, 1024);
    set_load_limit(11'd921);
    test_random(50, 16);
    drain();
    if (errors == 0) begin
      $display("quadratic_chain_hash_set_top: match");
    end else begin
      $display("quadratic_chain_hash_set_top: mismatch");
    end
    $finish;
  end
endmodule
